/* rtl/core/fsp_pkg.sv */
// Package: payload types, character codes, length codes and helpers of the format spec parser.
package fsp_pkg;

	typedef struct packed {
		logic [7:0] ch;
		logic       begin_req;
	} item_t;

	typedef struct packed {
		logic [4:0]  flag_bits;
		logic [15:0] field_width;
		logic        width_from_arg;
		logic [1:0]  precision_kind;
		logic [15:0] precision_value;
		logic [3:0]  length_code;
		logic [7:0]  conversion;
		logic        spec_valid;
		logic [7:0]  spec_chars;
	} result_t;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_H     = 8'h68;
	localparam logic [7:0] CH_L     = 8'h6C;
	localparam logic [7:0] CH_J     = 8'h6A;
	localparam logic [7:0] CH_Z     = 8'h7A;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_BIG_L = 8'h4C;

	localparam logic [4:0] FL_BLANK = 5'b00001;
	localparam logic [4:0] FL_LEFT  = 5'b00010;
	localparam logic [4:0] FL_SIGN  = 5'b00100;
	localparam logic [4:0] FL_ALT   = 5'b01000;
	localparam logic [4:0] FL_PAD   = 5'b10000;

	localparam logic [1:0] PREC_NONE  = 2'd0;
	localparam logic [1:0] PREC_EMPTY = 2'd1;
	localparam logic [1:0] PREC_STAR  = 2'd2;
	localparam logic [1:0] PREC_VALUE = 2'd3;

	localparam logic [3:0] LEN_NONE = 4'd0;
	localparam logic [3:0] LEN_HH   = 4'd1;
	localparam logic [3:0] LEN_H    = 4'd2;
	localparam logic [3:0] LEN_L    = 4'd3;
	localparam logic [3:0] LEN_LL   = 4'd4;
	localparam logic [3:0] LEN_J    = 4'd5;
	localparam logic [3:0] LEN_Z    = 4'd6;
	localparam logic [3:0] LEN_T    = 4'd7;
	localparam logic [3:0] LEN_BIG_L = 4'd8;

	localparam logic [7:0] COUNT_MAX = 8'hFF;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	// acc * 10 + digit, saturating at 16 bits
	function automatic logic [15:0] acc10(input logic [15:0] acc, input logic [7:0] c);
		logic [19:0] v;
		v = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {16'b0, c[3:0]};
		return (v > 20'hFFFF) ? 16'hFFFF : v[15:0];
	endfunction

	function automatic logic conv_ok(input logic [7:0] c);
		logic ok;
		unique case (c) inside
			8'h64, 8'h69, 8'h75, 8'h6F, 8'h78, 8'h58,
			8'h66, 8'h46, 8'h65, 8'h45, 8'h67, 8'h47,
			8'h61, 8'h41, 8'h63, 8'h73, 8'h70, 8'h6E,
			8'h25: ok = 1'b1;
			default: ok = 1'b0;
		endcase
		return ok;
	endfunction

endpackage

/* rtl/core/format_spec_parser_unit.sv */
// Top level of the printf format spec parser: input register, parse core, result register.
//
// Feed the characters after a percent sign one beat at a time, with begin_req set on the
// first; one descriptor beat comes out when the conversion letter (or a bad one) arrives.
// One character is taken every cycle, except that a beat ending a spec waits while the
// result register holds a stalled descriptor. A descriptor passes the input register and
// then the result register. The character rate is set by the parse state loop in the
// core: flag, width, precision and length decoding plus one times-ten add per character.
// While a descriptor waits on a stalled output, characters that produce no descriptor keep flowing through.
module format_spec_parser_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  fsp_pkg::item_t   item,
	output logic             res_valid,
	input  logic             res_stall,
	output fsp_pkg::result_t res
);

	logic             valid_s1;
	fsp_pkg::item_t   item_s1;
	logic             emit;
	logic             advance;
	fsp_pkg::result_t result;
	logic             res_valid_q;
	fsp_pkg::result_t res_q;

	assign advance    = valid_s1 && (!emit || !res_valid_q || !res_stall);
	assign item_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid)
			item_s1 <= item;
	end

	fsp_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (item_s1),
		.emit   (emit),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && emit) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit)
			res_q <= result;
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

/* rtl/core/fsp_core.sv */
// Parse state registers and the per-character transition logic.
module fsp_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  fsp_pkg::item_t   item,
	output logic             emit,
	output fsp_pkg::result_t result
);

	typedef enum logic [7:0] {
		PH_IDLE    = 8'b0000_0001,
		PH_FLAGS   = 8'b0000_0010,
		PH_WDIGITS = 8'b0000_0100,
		PH_PLC     = 8'b0000_1000,
		PH_DOT     = 8'b0001_0000,
		PH_PDIGITS = 8'b0010_0000,
		PH_LPEND   = 8'b0100_0000,
		PH_CONV    = 8'b1000_0000
	} phase_t;

	typedef struct packed {
		phase_t      phase;
		logic [4:0]  flags;
		logic [15:0] width_acc;
		logic        width_star;
		logic [1:0]  prec_kind;
		logic [15:0] prec_acc;
		logic [3:0]  len_code;
		logic [7:0]  count;
	} state_t;

	state_t cur_q;
	state_t nxt;

	always_comb begin
		logic [7:0]  c;
		logic        do_plc;
		logic        do_loc;
		logic        do_emit;
		logic        consume;
		logic        ok;
		logic [4:0]  bit_sel;
		logic [15:0] acc;
		c       = item.ch;
		nxt     = cur_q;
		do_plc  = 1'b0;
		do_loc  = 1'b0;
		do_emit = 1'b0;
		consume = 1'b0;
		ok      = 1'b0;
		bit_sel = '0;
		acc     = '0;
		result  = '0;
		if (item.begin_req) begin
			nxt.phase      = PH_FLAGS;
			nxt.flags      = '0;
			nxt.width_acc  = '0;
			nxt.width_star = 1'b0;
			nxt.prec_kind  = fsp_pkg::PREC_NONE;
			nxt.prec_acc   = '0;
			nxt.len_code   = fsp_pkg::LEN_NONE;
			nxt.count      = 8'd1;
		end
		unique case (nxt.phase)
			PH_IDLE: begin
			end
			PH_FLAGS: begin
				unique case (c)
					fsp_pkg::CH_SPACE: bit_sel = fsp_pkg::FL_BLANK;
					fsp_pkg::CH_MINUS: bit_sel = fsp_pkg::FL_LEFT;
					fsp_pkg::CH_PLUS:  bit_sel = fsp_pkg::FL_SIGN;
					fsp_pkg::CH_HASH:  bit_sel = fsp_pkg::FL_ALT;
					fsp_pkg::CH_ZERO:  bit_sel = fsp_pkg::FL_PAD;
					default:           bit_sel = '0;
				endcase
				if (bit_sel != '0) begin
					nxt.flags = nxt.flags | bit_sel;
					consume   = 1'b1;
				end else if (c == fsp_pkg::CH_STAR) begin
					nxt.width_star = 1'b1;
					nxt.phase      = PH_PLC;
					consume        = 1'b1;
				end else if (fsp_pkg::is_digit(c)) begin
					nxt.width_acc = fsp_pkg::acc10(nxt.width_acc, c);
					nxt.phase     = PH_WDIGITS;
					consume       = 1'b1;
				end else begin
					do_plc = 1'b1;
				end
			end
			PH_WDIGITS: begin
				if (fsp_pkg::is_digit(c)) begin
					nxt.width_acc = fsp_pkg::acc10(nxt.width_acc, c);
					consume       = 1'b1;
				end else begin
					do_plc = 1'b1;
				end
			end
			PH_PLC: do_plc = 1'b1;
			PH_DOT, PH_PDIGITS: begin
				if (nxt.phase == PH_DOT && c == fsp_pkg::CH_STAR) begin
					nxt.prec_kind = fsp_pkg::PREC_STAR;
					nxt.phase     = PH_PLC;
					consume       = 1'b1;
				end else if (fsp_pkg::is_digit(c)) begin
					acc           = fsp_pkg::acc10(nxt.prec_acc, c);
					nxt.prec_acc  = acc;
					nxt.prec_kind = (acc != '0) ? fsp_pkg::PREC_VALUE : fsp_pkg::PREC_EMPTY;
					nxt.phase     = PH_PDIGITS;
					consume       = 1'b1;
				end else begin
					if (nxt.phase == PH_DOT)
						nxt.prec_kind = fsp_pkg::PREC_EMPTY;
					do_loc = 1'b1;
				end
			end
			PH_LPEND: begin
				if (nxt.len_code == fsp_pkg::LEN_H && c == fsp_pkg::CH_H) begin
					nxt.len_code = fsp_pkg::LEN_HH;
					nxt.phase    = PH_CONV;
					consume      = 1'b1;
				end else if (nxt.len_code == fsp_pkg::LEN_L && c == fsp_pkg::CH_L) begin
					nxt.len_code = fsp_pkg::LEN_LL;
					nxt.phase    = PH_CONV;
					consume      = 1'b1;
				end else begin
					do_emit = 1'b1;
				end
			end
			PH_CONV: do_emit = 1'b1;
			default: begin
			end
		endcase
		if (do_plc) begin
			if (c == fsp_pkg::CH_DOT && nxt.prec_kind == fsp_pkg::PREC_NONE) begin
				nxt.phase = PH_DOT;
				consume   = 1'b1;
			end else begin
				do_loc = 1'b1;
			end
		end
		if (do_loc) begin
			unique case (c) inside
				fsp_pkg::CH_J, fsp_pkg::CH_Z, fsp_pkg::CH_T, fsp_pkg::CH_BIG_L: begin
					unique case (c)
						fsp_pkg::CH_J: nxt.len_code = fsp_pkg::LEN_J;
						fsp_pkg::CH_Z: nxt.len_code = fsp_pkg::LEN_Z;
						fsp_pkg::CH_T: nxt.len_code = fsp_pkg::LEN_T;
						default:       nxt.len_code = fsp_pkg::LEN_BIG_L;
					endcase
					nxt.phase = PH_CONV;
					consume   = 1'b1;
				end
				fsp_pkg::CH_H, fsp_pkg::CH_L: begin
					nxt.len_code = (c == fsp_pkg::CH_H) ? fsp_pkg::LEN_H : fsp_pkg::LEN_L;
					nxt.phase    = PH_LPEND;
					consume      = 1'b1;
				end
				default: do_emit = 1'b1;
			endcase
		end
		if (do_emit) begin
			ok        = fsp_pkg::conv_ok(c);
			consume   = ok;
			nxt.phase = PH_IDLE;
		end
		if (consume && nxt.count != fsp_pkg::COUNT_MAX)
			nxt.count = nxt.count + 8'd1;
		emit                   = do_emit;
		result.flag_bits       = nxt.flags;
		result.field_width     = nxt.width_acc;
		result.width_from_arg  = nxt.width_star;
		result.precision_kind  = nxt.prec_kind;
		result.precision_value = (nxt.prec_kind == fsp_pkg::PREC_VALUE) ? nxt.prec_acc : '0;
		result.length_code     = nxt.len_code;
		result.conversion      = ok ? c : '0;
		result.spec_valid      = ok;
		result.spec_chars      = nxt.count;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q.phase      <= PH_IDLE;
			cur_q.flags      <= '0;
			cur_q.width_acc  <= '0;
			cur_q.width_star <= 1'b0;
			cur_q.prec_kind  <= fsp_pkg::PREC_NONE;
			cur_q.prec_acc   <= '0;
			cur_q.len_code   <= fsp_pkg::LEN_NONE;
			cur_q.count      <= '0;
		end else if (fire) begin
			cur_q <= nxt;
		end
	end

endmodule

/* rtl/core/fsp_checker.sv */
// Port-level checks for the format spec parser, bound to the top level.
module fsp_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             item_valid,
	input logic             item_stall,
	input fsp_pkg::item_t   item,
	input logic             res_valid,
	input logic             res_stall,
	input fsp_pkg::result_t res
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("descriptor beat dropped or changed while stalled");

	a_bad_conv: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.spec_valid |-> res.conversion == 8'h00)
		else $error("invalid descriptor carries a conversion code");

	a_prec_val: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.precision_kind != fsp_pkg::PREC_VALUE |-> res.precision_value == 16'h0)
		else $error("precision value without explicit precision");

	a_min_chars: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.spec_valid |-> res.spec_chars >= 8'd2)
		else $error("valid descriptor counts fewer than two characters");

endmodule

bind format_spec_parser_unit fsp_checker u_fsp_checker (.*);

/* dv/tb.sv */
// Testbench for format_spec_parser_unit: printf spec stimulus, descriptor prediction and checks.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fsp_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int ITEM_TARGET  = 450;
	localparam int DRAIN_CYCLES = 20;
	localparam int SEND_GAP [3] = '{19, 80, 0};
	localparam int RECV_GAP [3] = '{80, 19, 0};

	localparam logic [7:0] FLAG_CH [5] = '{CH_SPACE, CH_MINUS, CH_PLUS, CH_HASH, CH_ZERO};
	localparam logic [7:0] CONV_SET [19] = '{"d", "i", "u", "o", "x", "X", "f", "F", "e",
		"E", "g", "G", "a", "A", "c", "s", "p", "n", "%"};

	typedef enum logic [2:0] {
		SP_IDLE, SP_FLAGS, SP_WIDTH, SP_AFTER_W, SP_DOT, SP_PREC, SP_LEN2, SP_LETTER
	} spec_phase_t;

	typedef struct {
		item_t it;
		bit    hold;
	} pend_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_stall;
	item_t   item = '0;
	logic    res_valid;
	logic    res_stall = 1'b0;
	result_t res;

	pend_t      char_q[$];
	result_t    descr_q[$];
	logic [7:0] spec_buf[$];
	result_t    want;
	int         total_items;
	int         n_taken;
	int         err_count;
	int         cycles;

	// predictor state
	spec_phase_t ph;
	logic [4:0]  flags_r;
	logic [15:0] wid_r;
	logic        wstar_r;
	logic [1:0]  pkind_r;
	logic [15:0] pacc_r;
	logic [3:0]  len_r;
	logic [7:0]  cnt_r;

	format_spec_parser_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res        (res)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic logic dec_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic [15:0] mul10_sat(input logic [15:0] acc, input logic [7:0] c);
		logic [31:0] v;
		v = {16'b0, acc} * 32'd10 + {24'b0, c - CH_ZERO};
		return (v > 32'hFFFF) ? 16'hFFFF : v[15:0];
	endfunction

	function automatic logic known_conversion(input logic [7:0] c);
		foreach (CONV_SET[i])
			if (c == CONV_SET[i])
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic logic [7:0] digit_ch(input int unsigned v);
		return CH_ZERO + v[7:0];
	endfunction

	function automatic int stage_now();
		if (n_taken * 3 < total_items)
			return 0;
		if (n_taken * 3 < 2 * total_items)
			return 1;
		return 2;
	endfunction

	function automatic string descr_text(input result_t r);
		return $sformatf("flags=%b width=%0d wstar=%b pkind=%0d pval=%0d len=%0d conv=%h ok=%b n=%0d",
			r.flag_bits, r.field_width, r.width_from_arg, r.precision_kind,
			r.precision_value, r.length_code, r.conversion, r.spec_valid, r.spec_chars);
	endfunction

	task automatic clear_spec();
		ph = SP_IDLE;
		flags_r = '0;
		wid_r = '0;
		wstar_r = 1'b0;
		pkind_r = PREC_NONE;
		pacc_r = '0;
		len_r = LEN_NONE;
		cnt_r = '0;
	endtask

	task automatic bump();
		if (cnt_r != COUNT_MAX)
			cnt_r = cnt_r + 8'd1;
	endtask

	task automatic end_spec(input logic [7:0] c);
		logic    ok;
		result_t r;
		ok = known_conversion(c);
		if (ok)
			bump();
		r.flag_bits = flags_r;
		r.field_width = wid_r;
		r.width_from_arg = wstar_r;
		r.precision_kind = pkind_r;
		r.precision_value = (pkind_r == PREC_VALUE) ? pacc_r : 16'h0000;
		r.length_code = len_r;
		r.conversion = ok ? c : 8'h00;
		r.spec_valid = ok;
		r.spec_chars = cnt_r;
		descr_q.push_back(r);
		ph = SP_IDLE;
	endtask

	task automatic length_or_letter(input logic [7:0] c);
		if (c == CH_J || c == CH_Z || c == CH_T || c == CH_BIG_L) begin
			len_r = (c == CH_J) ? LEN_J : (c == CH_Z) ? LEN_Z : (c == CH_T) ? LEN_T : LEN_BIG_L;
			bump();
			ph = SP_LETTER;
		end else if (c == CH_H || c == CH_L) begin
			len_r = (c == CH_H) ? LEN_H : LEN_L;
			bump();
			ph = SP_LEN2;
		end else begin
			end_spec(c);
		end
	endtask

	task automatic dot_or_rest(input logic [7:0] c);
		if (c == CH_DOT && pkind_r == PREC_NONE) begin
			bump();
			ph = SP_DOT;
		end else begin
			length_or_letter(c);
		end
	endtask

	task automatic take_prec_digit(input logic [7:0] c);
		pacc_r = mul10_sat(pacc_r, c);
		pkind_r = (pacc_r != 16'h0000) ? PREC_VALUE : PREC_EMPTY;
		bump();
		ph = SP_PREC;
	endtask

	task automatic parse_char(input item_t it);
		logic [7:0] c;
		logic [4:0] fb;
		c = it.ch;
		if (it.begin_req) begin
			clear_spec();
			cnt_r = 8'd1;
			ph = SP_FLAGS;
		end
		case (ph)
			SP_FLAGS: begin
				case (c)
					CH_SPACE: fb = FL_BLANK;
					CH_MINUS: fb = FL_LEFT;
					CH_PLUS:  fb = FL_SIGN;
					CH_HASH:  fb = FL_ALT;
					CH_ZERO:  fb = FL_PAD;
					default:  fb = '0;
				endcase
				if (fb != '0) begin
					flags_r = flags_r | fb;
					bump();
				end else if (c == CH_STAR) begin
					wstar_r = 1'b1;
					bump();
					ph = SP_AFTER_W;
				end else if (dec_digit(c)) begin
					wid_r = mul10_sat(wid_r, c);
					bump();
					ph = SP_WIDTH;
				end else begin
					dot_or_rest(c);
				end
			end
			SP_WIDTH: begin
				if (dec_digit(c)) begin
					wid_r = mul10_sat(wid_r, c);
					bump();
				end else begin
					dot_or_rest(c);
				end
			end
			SP_AFTER_W: dot_or_rest(c);
			SP_DOT: begin
				if (c == CH_STAR) begin
					pkind_r = PREC_STAR;
					bump();
					ph = SP_AFTER_W;
				end else if (dec_digit(c)) begin
					take_prec_digit(c);
				end else begin
					pkind_r = PREC_EMPTY;
					length_or_letter(c);
				end
			end
			SP_PREC: begin
				if (dec_digit(c))
					take_prec_digit(c);
				else
					length_or_letter(c);
			end
			SP_LEN2: begin
				if (len_r == LEN_H && c == CH_H) begin
					len_r = LEN_HH;
					bump();
					ph = SP_LETTER;
				end else if (len_r == LEN_L && c == CH_L) begin
					len_r = LEN_LL;
					bump();
					ph = SP_LETTER;
				end else begin
					end_spec(c);
				end
			end
			SP_LETTER: end_spec(c);
			default: ;
		endcase
	endtask

	task automatic log_mismatch(input string msg);
		if (err_count < 10)
			$display("%s", msg);
		err_count++;
	endtask

	// spec_buf holds the characters after the percent sign; first one carries begin_req
	task automatic queue_spec(input bit hold);
		pend_t p;
		foreach (spec_buf[i]) begin
			p.it.ch = spec_buf[i];
			p.it.begin_req = (i == 0);
			p.hold = hold && (i == 0);
			char_q.push_back(p);
		end
	endtask

	task automatic queue_text(input string t);
		spec_buf.delete();
		for (int i = 0; i < t.len(); i++)
			spec_buf.push_back(t[i]);
		queue_spec(1'b0);
	endtask

	task automatic queue_noise(input logic [7:0] c);
		pend_t p;
		p.it.ch = c;
		p.it.begin_req = 1'b0;
		p.hold = 1'b0;
		char_q.push_back(p);
	endtask

	task automatic make_spec(input bit whole);
		int unsigned r;
		int unsigned keep;
		spec_buf.delete();
		if ($urandom_range(1))
			repeat ($urandom_range(1, 4))
				spec_buf.push_back(FLAG_CH[$urandom_range(4)]);
		r = $urandom_range(9);
		if (r == 4 || r == 5) begin
			spec_buf.push_back(CH_STAR);
		end else if (r >= 6) begin
			spec_buf.push_back(digit_ch($urandom_range(1, 9)));
			repeat (($urandom_range(9) == 0) ? $urandom_range(4, 6) : $urandom_range(3))
				spec_buf.push_back(digit_ch($urandom_range(9)));
		end
		r = $urandom_range(9);
		if (r >= 5)
			spec_buf.push_back(CH_DOT);
		if (r == 6) begin
			spec_buf.push_back(CH_STAR);
		end else if (r >= 7) begin
			if ($urandom_range(3) == 0)
				repeat ($urandom_range(1, 3))
					spec_buf.push_back(CH_ZERO);
			else
				repeat (($urandom_range(7) == 0) ? $urandom_range(5, 6) : $urandom_range(1, 3))
					spec_buf.push_back(digit_ch($urandom_range(9)));
		end
		if ($urandom_range(9) >= 4) begin
			case ($urandom_range(7))
				0: begin
					spec_buf.push_back(CH_H);
					spec_buf.push_back(CH_H);
				end
				1: spec_buf.push_back(CH_H);
				2: spec_buf.push_back(CH_L);
				3: begin
					spec_buf.push_back(CH_L);
					spec_buf.push_back(CH_L);
				end
				4: spec_buf.push_back(CH_J);
				5: spec_buf.push_back(CH_Z);
				6: spec_buf.push_back(CH_T);
				default: spec_buf.push_back(CH_BIG_L);
			endcase
		end
		if (whole) begin
			if ($urandom_range(99) < 85)
				spec_buf.push_back(CONV_SET[$urandom_range(18)]);
			else
				spec_buf.push_back(8'($urandom_range(255)));
		end else begin
			// cut short; the next spec restarts over it
			keep = $urandom_range(1, 6);
			while (spec_buf.size() > keep)
				void'(spec_buf.pop_back());
			if (spec_buf.size() == 0)
				spec_buf.push_back(8'($urandom_range(255)));
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			item <= '0;
		end else if (!item_valid || !item_stall) begin
			if (char_q.size() != 0 && char_q[0].hold && (descr_q.size() != 0 || item_valid)) begin
				item_valid <= 1'b0;
			end else if (char_q.size() != 0 && $urandom_range(99) >= SEND_GAP[stage_now()]) begin
				item <= char_q[0].it;
				item_valid <= 1'b1;
				char_q.delete(0);
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_stall <= 1'b0;
		else
			res_stall <= ($urandom_range(99) < RECV_GAP[stage_now()]);
	end

	// prediction on each accepted input beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_spec();
		end else if (item_valid && !item_stall) begin
			parse_char(item);
			n_taken++;
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (descr_q.size() == 0) begin
				log_mismatch($sformatf("%0t: descriptor with none pending: %s", $time,
					descr_text(res)));
			end else begin
				want = descr_q.pop_front();
				if (want.flag_bits !== res.flag_bits || want.field_width !== res.field_width ||
					want.width_from_arg !== res.width_from_arg ||
					want.precision_kind !== res.precision_kind ||
					want.precision_value !== res.precision_value ||
					want.length_code !== res.length_code || want.conversion !== res.conversion ||
					want.spec_valid !== res.spec_valid || want.spec_chars !== res.spec_chars)
					log_mismatch($sformatf("%0t: descriptor mismatch\n  exp %s\n  got %s", $time,
						descr_text(want), descr_text(res)));
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		int unsigned pick;
		int          n_specs;
		n_taken = 0;
		err_count = 0;
		cycles = 0;
		n_specs = 0;

		queue_noise("Q");
		queue_text("#-+ 070000lld");
		queue_text("*.*hhi");
		queue_text(".99999Lq");
		queue_text("3.0zu");
		queue_text("12");
		queue_text("hx");
		queue_text(".lo");

		while (char_q.size() < ITEM_TARGET) begin
			pick = $urandom_range(99);
			if (pick < 8) begin
				repeat ($urandom_range(1, 3))
					queue_noise(8'($urandom_range(255)));
			end else begin
				make_spec(pick < 90);
				queue_spec(n_specs % 60 == 0);
				n_specs++;
			end
			if (n_specs == 20) begin
				// long run of flags to saturate the character count
				spec_buf.delete();
				repeat (259)
					spec_buf.push_back(FLAG_CH[$urandom_range(4)]);
				spec_buf.push_back(CONV_SET[$urandom_range(18)]);
				queue_spec(1'b1);
				n_specs++;
			end
		end
		total_items = char_q.size();

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (char_q.size() != 0 || item_valid)
			@(posedge clk);
		while (descr_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (err_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

/* sim.f */
rtl/core/fsp_pkg.sv
rtl/core/fsp_core.sv
rtl/core/format_spec_parser_unit.sv
rtl/core/fsp_checker.sv
dv/tb.sv
